@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: payload structs,
// command codes, control codes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Command codes of the request channel
   typedef enum logic [2:0] {
      OP_PUT_CHAR = 3'd0,
      OP_SET_BG   = 3'd1,
      OP_SET_FG   = 3'd2,
      OP_PUSH     = 3'd3,
      OP_POP      = 3'd4,
      OP_CLEAR    = 3'd5,
      OP_READ     = 3'd6
   } op_type;

   // Control codes of put char
   localparam logic [7:0] CH_NUL = 8'd0;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_BG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_FG = 1'd1;

   // Reset values of the default colours
   localparam logic [3:0] RESET_DEF_BG = 4'd0;
   localparam logic [3:0] RESET_DEF_FG = 4'd7;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  char_code;
      logic [3:0]  new_color;
      logic [10:0] cell_index;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] cell_word;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_offset;
      logic        success;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_READ_WAIT,
      ST_CLEAR,
      ST_SCROLL_COPY,
      ST_SCROLL_DRAIN,
      ST_SCROLL_FILL,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic req_ready;
      logic latch_item;
      logic exec;
      logic pop_apply;
      logic read_capture;
      logic init_write;
      logic fill_write;
      logic copy_step;
      logic sweep_step;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       scroll_needed;
      logic       stack_full;
      logic       stack_empty;
      logic       index_ok;
      logic       sweep_last;
      logic       copy_last;
      logic       rsp_free;
   } dp_status_type;

endpackage

@@ design/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller of the text console writer: sequences the reset clearing pass,
// the per-item execute step, read and pop waits, clears, scrolls and the
// handover of each result beat to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  tcw_pkg::dp_status_type sts,
   output tcw_pkg::ctrl_cmd_type  cmd
);

   tcw_pkg::state_type state_ff;
   tcw_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (sts.sweep_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            case (tcw_pkg::op_type'(sts.op))
               tcw_pkg::OP_PUT_CHAR: begin
                  state_in = sts.scroll_needed ? tcw_pkg::ST_SCROLL_COPY : tcw_pkg::ST_DONE;
               end
               tcw_pkg::OP_POP: begin
                  state_in = sts.stack_empty ? tcw_pkg::ST_DONE : tcw_pkg::ST_POP_WAIT;
               end
               tcw_pkg::OP_CLEAR: begin
                  state_in = tcw_pkg::ST_CLEAR;
               end
               tcw_pkg::OP_READ: begin
                  state_in = sts.index_ok ? tcw_pkg::ST_READ_WAIT : tcw_pkg::ST_DONE;
               end
               default: begin
                  state_in = tcw_pkg::ST_DONE;
               end
            endcase
         end
         tcw_pkg::ST_POP_WAIT: begin
            state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_READ_WAIT: begin
            state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_CLEAR: begin
            if (sts.sweep_last) begin
               state_in = tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_SCROLL_COPY: begin
            if (sts.copy_last) begin
               state_in = tcw_pkg::ST_SCROLL_DRAIN;
            end
         end
         tcw_pkg::ST_SCROLL_DRAIN: begin
            state_in = tcw_pkg::ST_SCROLL_FILL;
         end
         tcw_pkg::ST_SCROLL_FILL: begin
            if (sts.sweep_last) begin
               state_in = tcw_pkg::ST_DONE;
            end
         end
         tcw_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               state_in = req_valid ? tcw_pkg::ST_EXEC : tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_INIT;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            cmd.init_write = 1'b1;
            cmd.sweep_step = 1'b1;
         end
         tcw_pkg::ST_IDLE: begin
            cmd.req_ready  = 1'b1;
            cmd.latch_item = req_valid;
         end
         tcw_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         tcw_pkg::ST_POP_WAIT: begin
            cmd.pop_apply = 1'b1;
         end
         tcw_pkg::ST_READ_WAIT: begin
            cmd.read_capture = 1'b1;
         end
         tcw_pkg::ST_CLEAR: begin
            cmd.fill_write = 1'b1;
            cmd.sweep_step = 1'b1;
         end
         tcw_pkg::ST_SCROLL_COPY: begin
            cmd.copy_step  = 1'b1;
            cmd.sweep_step = 1'b1;
         end
         tcw_pkg::ST_SCROLL_DRAIN: begin
            // last copy write drains on its own
         end
         tcw_pkg::ST_SCROLL_FILL: begin
            cmd.fill_write = 1'b1;
            cmd.sweep_step = 1'b1;
         end
         tcw_pkg::ST_DONE: begin
            cmd.load_rsp   = sts.rsp_free;
            cmd.req_ready  = sts.rsp_free;
            cmd.latch_item = sts.rsp_free & req_valid;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ design/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath of the text console writer: screen and colour stack memories,
// cursor and colour registers, sweep counter for clears and scrolls, default
// colour registers and the result output register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int STACK_DEPTH    = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tcw_pkg::ctrl_cmd_type              cmd,
   output tcw_pkg::dp_status_type             sts,
   input  tcw_pkg::req_payload_type           req_payload,
   input  logic                               csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tcw_pkg::rsp_payload_type           rsp_payload
);

   localparam int CELL_TOTAL = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W     = $clog2(CELL_TOTAL);
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int SA_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [6:0]        COL_LAST   = 7'(SCREEN_COLUMNS - 1);
   localparam logic [4:0]        ROW_LAST   = 5'(SCREEN_ROWS - 1);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(CELL_TOTAL - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELL_TOTAL - SCREEN_COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLUMNS);
   localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(STACK_DEPTH);

   // Registers
   tcw_pkg::req_payload_type item_ff, item_in;
   logic [6:0]        col_ff, col_in;
   logic [4:0]        row_ff, row_in;
   logic [3:0]        cur_bg_ff, cur_bg_in;
   logic [3:0]        cur_fg_ff, cur_fg_in;
   logic [3:0]        def_bg_ff, def_bg_in;
   logic [3:0]        def_fg_ff, def_fg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0] copy_addr_ff, copy_addr_in;
   logic [15:0]       word_ff, word_in;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_payload_type rsp_ff, rsp_in;

   // Memory ports
   logic              scr_we;
   logic [ADDR_W-1:0] scr_waddr;
   logic [15:0]       scr_wdata;
   logic              scr_re;
   logic [ADDR_W-1:0] scr_raddr;
   logic [15:0]       scr_rdata;
   logic              stk_we;
   logic              stk_re;
   logic [SA_W-1:0]   stk_waddr;
   logic [SA_W-1:0]   stk_raddr;
   logic [7:0]        stk_rdata;

   // Decode
   tcw_pkg::op_type   op;
   logic              printable;
   logic              row_is_last;
   logic [4:0]        row_down;
   logic [ADDR_W-1:0] pos;
   logic              stack_full;
   logic              stack_empty;
   logic              index_ok;
   logic              rsp_free;

   assign op          = tcw_pkg::op_type'(item_ff.command);
   assign printable   = (item_ff.char_code != tcw_pkg::CH_NUL) &&
                        (item_ff.char_code != tcw_pkg::CH_BS) &&
                        (item_ff.char_code != tcw_pkg::CH_LF) &&
                        (item_ff.char_code != tcw_pkg::CH_CR);
   assign row_is_last = (row_ff == ROW_LAST);
   // line feed: bottom row stays, the scroll moves the text instead
   assign row_down    = row_is_last ? row_ff : row_ff + 5'd1;
   assign pos         = ADDR_W'(row_ff) * ROW_STRIDE + ADDR_W'(col_ff);
   assign stack_full  = (count_ff == CNT_FULL);
   assign stack_empty = (count_ff == '0);
   assign index_ok    = ({21'd0, item_ff.cell_index} < CELL_TOTAL);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // Status to the controller
   always_comb begin
      sts.op            = item_ff.command;
      sts.scroll_needed = row_is_last &&
                          ((item_ff.char_code == tcw_pkg::CH_LF) ||
                           (printable && (col_ff == COL_LAST)));
      sts.stack_full    = stack_full;
      sts.stack_empty   = stack_empty;
      sts.index_ok      = index_ok;
      sts.sweep_last    = (sweep_ff == SWEEP_LAST);
      sts.copy_last     = (sweep_ff == COPY_LAST);
      sts.rsp_free      = rsp_free;
   end

   // Next values of the architectural registers
   always_comb begin
      item_in      = item_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cur_bg_in    = cur_bg_ff;
      cur_fg_in    = cur_fg_ff;
      def_bg_in    = def_bg_ff;
      def_fg_in    = def_fg_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      ok_in        = ok_ff;

      if (cmd.latch_item) begin
         item_in = req_payload;
      end

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            tcw_pkg::CSR_DEF_BG: def_bg_in = csr_wdata;
            tcw_pkg::CSR_DEF_FG: def_fg_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (cmd.exec) begin
         word_in = '0;
         ok_in   = 1'b1;
         case (op)
            tcw_pkg::OP_PUT_CHAR: begin
               case (item_ff.char_code)
                  tcw_pkg::CH_NUL: begin
                  end
                  tcw_pkg::CH_BS: begin
                     if (col_ff == '0) begin
                        col_in = COL_LAST;
                        row_in = (row_ff == '0) ? ROW_LAST : row_ff - 5'd1;
                     end else begin
                        col_in = col_ff - 7'd1;
                     end
                  end
                  tcw_pkg::CH_LF: begin
                     col_in = '0;
                     row_in = row_down;
                  end
                  tcw_pkg::CH_CR: begin
                     col_in = '0;
                  end
                  default: begin
                     if (col_ff == COL_LAST) begin
                        col_in = '0;
                        row_in = row_down;
                     end else begin
                        col_in = col_ff + 7'd1;
                     end
                  end
               endcase
            end
            tcw_pkg::OP_SET_BG: cur_bg_in = item_ff.new_color;
            tcw_pkg::OP_SET_FG: cur_fg_in = item_ff.new_color;
            tcw_pkg::OP_PUSH: begin
               if (stack_full) begin
                  ok_in = 1'b0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            tcw_pkg::OP_POP: begin
               if (stack_empty) begin
                  ok_in = 1'b0;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // pop data arrives in the cycle after the read
      if (cmd.pop_apply) begin
         cur_bg_in = stk_rdata[7:4];
         cur_fg_in = stk_rdata[3:0];
      end

      if (cmd.read_capture) begin
         word_in = scr_rdata;
      end
   end

   // Sweep counter and scroll copy pipeline
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_step) begin
         sweep_in = (sweep_ff == SWEEP_LAST) ? '0 : sweep_ff + 1'b1;
      end
      copy_pend_in = cmd.copy_step;
      copy_addr_in = sweep_ff;
   end

   // Screen memory ports
   always_comb begin
      scr_we    = 1'b0;
      scr_waddr = sweep_ff;
      scr_wdata = {def_bg_ff, def_fg_ff, 8'd0};
      if (cmd.exec && (op == tcw_pkg::OP_PUT_CHAR) && printable) begin
         scr_we    = 1'b1;
         scr_waddr = pos;
         scr_wdata = {cur_bg_ff, cur_fg_ff, item_ff.char_code};
      end else if (copy_pend_ff) begin
         scr_we    = 1'b1;
         scr_waddr = copy_addr_ff;
         scr_wdata = scr_rdata;
      end else if (cmd.fill_write) begin
         scr_we    = 1'b1;
      end else if (cmd.init_write) begin
         scr_we    = 1'b1;
         scr_wdata = {tcw_pkg::RESET_DEF_BG, tcw_pkg::RESET_DEF_FG, 8'd0};
      end

      scr_re    = 1'b0;
      scr_raddr = sweep_ff + ROW_STRIDE;
      if (cmd.copy_step) begin
         scr_re = 1'b1;
      end else if (cmd.exec && (op == tcw_pkg::OP_READ) && index_ok) begin
         scr_re    = 1'b1;
         scr_raddr = ADDR_W'(item_ff.cell_index);
      end
   end

   // Stack memory ports
   assign stk_we    = cmd.exec && (op == tcw_pkg::OP_PUSH) && !stack_full;
   assign stk_waddr = SA_W'(count_ff);
   assign stk_re    = cmd.exec && (op == tcw_pkg::OP_POP) && !stack_empty;
   assign stk_raddr = SA_W'(count_ff - 1'b1);

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in         = 1'b1;
         rsp_in.cell_word     = word_ff;
         rsp_in.cursor_column = col_ff;
         rsp_in.cursor_row    = row_ff;
         rsp_in.cursor_offset = 11'(pos);
         rsp_in.success       = ok_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cur_bg_ff    <= tcw_pkg::RESET_DEF_BG;
         cur_fg_ff    <= tcw_pkg::RESET_DEF_FG;
         def_bg_ff    <= tcw_pkg::RESET_DEF_BG;
         def_fg_ff    <= tcw_pkg::RESET_DEF_FG;
         count_ff     <= '0;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         cur_bg_ff    <= cur_bg_in;
         cur_fg_ff    <= cur_fg_in;
         def_bg_ff    <= def_bg_in;
         def_fg_ff    <= def_fg_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      copy_addr_ff <= copy_addr_in;
      word_ff      <= word_in;
      ok_ff        <= ok_in;
      rsp_ff       <= rsp_in;
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_TOTAL)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_waddr),
      .wr_data (scr_wdata),
      .rd_en   (scr_re),
      .rd_addr (scr_raddr),
      .rd_data (scr_rdata)
   );

   tcw_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data ({cur_bg_ff, cur_fg_ff}),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/text_console_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell screen store with a cursor, colour registers, a colour
// stack, clear, scroll and cell read-back.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_valid / req_stall  req_payload  (command, char, colour, index)
//   rsp      out  rsp_valid / rsp_stall  rsp_payload  (cell word, cursor, success)
//   csr      in   csr_write_en           csr_index, csr_wdata
//
// Most items execute and then hand the beat to the output register; an
// in-range read cell and a pop of a non-empty stack add a wait state
// because of the registered memory read.
// Clear sweeps every cell, and a scroll copies each row up and then
// blanks the last row, both paced by the single write port of the screen
// memory (one cell per cycle). After reset a clearing pass over every
// cell runs before the first item is taken.
// A held result beat stalls the block only when the next result is ready.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int STACK_DEPTH    = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tcw_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tcw_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_write_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tcw_pkg::ctrl_cmd_type  cmd;
   tcw_pkg::dp_status_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .STACK_DEPTH    (STACK_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // Hold off the requester while an item is at work
   assign req_stall = !cmd.req_ready;

`ifndef NO_ASSERTIONS
   // Cursor in a result beat stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_payload.cursor_column) < SCREEN_COLUMNS) &&
                    (32'(rsp_payload.cursor_row) < SCREEN_ROWS))
      else $error("cursor outside the screen");

   // Linear offset agrees with row and column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.cursor_offset ==
         11'(32'(rsp_payload.cursor_row) * SCREEN_COLUMNS +
             32'(rsp_payload.cursor_column)))
      else $error("cursor offset mismatch");

   // An accepted item keeps the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while executing");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_console_writer_core. A mirror of the screen,
// cursor, colours and colour stack predicts the result beat of every accepted
// command; the monitor compares each result beat field by field. Directed
// corner cases come first, then random phases under several default colours,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int COLS        = 80;
   localparam int ROWS        = 25;
   localparam int DEPTH       = 32;
   localparam int CELL_COUNT  = COLS * ROWS;
   localparam int MAX_GAP     = 15;
   localparam logic [2:0] OP_SPARE = 3'd7;

   // Mirror of the console state; predicts one result beat per command
   class console_mirror;
      logic [15:0]     cells [CELL_COUNT];
      logic [6:0]      col;
      logic [4:0]      row;
      logic [3:0]      cur_bg;
      logic [3:0]      cur_fg;
      logic [3:0]      def_bg;
      logic [3:0]      def_fg;
      logic [7:0]      saved_colors [DEPTH];
      int              saved_count;
      tcw_pkg::rsp_payload_type reports [$];
      int              faults;

      function new();
         def_bg      = tcw_pkg::RESET_DEF_BG;
         def_fg      = tcw_pkg::RESET_DEF_FG;
         cur_bg      = def_bg;
         cur_fg      = def_fg;
         col         = '0;
         row         = '0;
         saved_count = 0;
         faults      = 0;
         blank_all();
      endfunction

      function void set_defaults(logic [3:0] bg, logic [3:0] fg);
         def_bg = bg;
         def_fg = fg;
      endfunction

      function int pending();
         return reports.size();
      endfunction

      function int cursor_offset();
         return int'(row) * COLS + int'(col);
      endfunction

      function void blank_all();
         foreach (cells[i]) cells[i] = {def_bg, def_fg, 8'h00};
      endfunction

      // Move down one row; at the bottom, scroll up and blank the last row
      function void line_feed();
         if (int'(row) == ROWS - 1) begin
            for (int i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
            for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
               cells[i] = {def_bg, def_fg, 8'h00};
         end else begin
            row = row + 5'd1;
         end
      endfunction

      function void print_byte(logic [7:0] code);
         case (code)
            tcw_pkg::CH_NUL: ;
            tcw_pkg::CH_BS: begin
               if (col == '0) begin
                  col = 7'(COLS - 1);
                  row = (row == '0) ? 5'(ROWS - 1) : row - 5'd1;
               end else begin
                  col = col - 7'd1;
               end
            end
            tcw_pkg::CH_LF: begin
               line_feed();
               col = '0;
            end
            tcw_pkg::CH_CR: col = '0;
            default: begin
               cells[cursor_offset()] = {cur_bg, cur_fg, code};
               col = col + 7'd1;
               if (int'(col) >= COLS) begin
                  col = '0;
                  line_feed();
               end
            end
         endcase
      endfunction

      // Apply one accepted command and queue the result beat it must give
      function void accept_command(tcw_pkg::req_payload_type req);
         tcw_pkg::rsp_payload_type rep;
         rep         = '0;
         rep.success = 1'b1;
         case (req.command)
            tcw_pkg::OP_PUT_CHAR: print_byte(req.char_code);
            tcw_pkg::OP_SET_BG:   cur_bg = req.new_color;
            tcw_pkg::OP_SET_FG:   cur_fg = req.new_color;
            tcw_pkg::OP_PUSH: begin
               if (saved_count >= DEPTH) begin
                  rep.success = 1'b0;
               end else begin
                  saved_colors[saved_count] = {cur_bg, cur_fg};
                  saved_count++;
               end
            end
            tcw_pkg::OP_POP: begin
               if (saved_count == 0) begin
                  rep.success = 1'b0;
               end else begin
                  saved_count--;
                  {cur_bg, cur_fg} = saved_colors[saved_count];
               end
            end
            tcw_pkg::OP_CLEAR: blank_all();
            tcw_pkg::OP_READ: begin
               if (int'(req.cell_index) < CELL_COUNT) rep.cell_word = cells[req.cell_index];
            end
            default: ;
         endcase
         rep.cursor_column = col;
         rep.cursor_row    = row;
         rep.cursor_offset = 11'(cursor_offset());
         reports.push_back(rep);
      endfunction

      function void check_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            faults++;
         end
      endfunction

      function void compare_report(tcw_pkg::rsp_payload_type got);
         tcw_pkg::rsp_payload_type want;
         if (reports.size() == 0) begin
            $error("result beat with no command outstanding: 0x%0h", got);
            faults++;
            return;
         end
         want = reports.pop_front();
         check_field("cell_word", want.cell_word, got.cell_word);
         check_field("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
         check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
         check_field("cursor_offset", 16'(want.cursor_offset), 16'(got.cursor_offset));
         check_field("success", 16'(want.success), 16'(got.success));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   tcw_pkg::req_payload_type        req_payload;
   logic                            rsp_valid;
   logic                            rsp_stall;
   tcw_pkg::rsp_payload_type        rsp_payload;
   logic                            csr_write_en;
   logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [tcw_pkg::CSR_DATA_W-1:0]  csr_wdata;

   console_mirror board;
   bit            calm;

   text_console_writer_core #(
      .SCREEN_COLUMNS(COLS),
      .SCREEN_ROWS   (ROWS),
      .STACK_DEPTH   (DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Idle cycles before a beat; none while in a calm stretch
   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   // Read index somewhere behind the cursor, where text was written lately
   function automatic logic [10:0] near_cursor();
      int idx;
      idx = board.cursor_offset() - int'($urandom_range(0, 100));
      if (idx < 0) idx = 0;
      return 11'(idx);
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 9))
         0:       return tcw_pkg::CH_NUL;
         1:       return tcw_pkg::CH_BS;
         2:       return tcw_pkg::CH_LF;
         3:       return tcw_pkg::CH_CR;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] printable();
      return 8'($urandom_range(32, 255));
   endfunction

   // Drive one request beat, hold it until accepted, then update the mirror
   task automatic issue(input logic [2:0] cmd, input logic [7:0] code,
                        input logic [3:0] color, input logic [10:0] idx);
      tcw_pkg::req_payload_type item;
      int                       gap;
      item.command    = cmd;
      item.char_code  = code;
      item.new_color  = color;
      item.cell_index = idx;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.accept_command(item);
   endtask

   task automatic put(input logic [7:0] code);
      issue(tcw_pkg::OP_PUT_CHAR, code, 4'($urandom), 11'($urandom));
   endtask

   task automatic set_color(input logic [2:0] op, input logic [3:0] color);
      issue(op, 8'($urandom), color, 11'($urandom));
   endtask

   task automatic plain(input logic [2:0] op);
      issue(op, 8'($urandom), 4'($urandom), 11'($urandom));
   endtask

   task automatic read_cell(input logic [10:0] idx);
      issue(tcw_pkg::OP_READ, 8'($urandom), 4'($urandom), idx);
   endtask

   // Print one byte and read it back, so the current colours show up
   task automatic stamp(inout int sent);
      int idx;
      idx = board.cursor_offset();
      put(printable());
      read_cell(11'(idx));
      sent += 2;
   endtask

   // Drop valid and wait until every result beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_defaults(input logic [3:0] bg, input logic [3:0] fg);
      csr_write_en <= 1'b1;
      csr_index    <= tcw_pkg::CSR_DEF_BG;
      csr_wdata    <= bg;
      @(posedge clock);
      csr_index    <= tcw_pkg::CSR_DEF_FG;
      csr_wdata    <= fg;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.set_defaults(bg, fg);
   endtask

   task automatic directed_checks();
      put(8'h41);
      put(8'hff);
      put(8'h01);
      put(tcw_pkg::CH_NUL);
      put(tcw_pkg::CH_CR);
      // backspace from the top-left corner lands on the bottom-right cell
      put(tcw_pkg::CH_BS);
      // printing there wraps and scrolls
      put(8'h7f);
      read_cell(11'(CELL_COUNT - COLS - 1));
      put(tcw_pkg::CH_BS);
      put(tcw_pkg::CH_LF);
      put(tcw_pkg::CH_LF);
      set_color(tcw_pkg::OP_SET_BG, 4'hf);
      set_color(tcw_pkg::OP_SET_FG, 4'h0);
      plain(tcw_pkg::OP_PUSH);
      set_color(tcw_pkg::OP_SET_BG, 4'h0);
      set_color(tcw_pkg::OP_SET_FG, 4'hf);
      put(8'h80);
      plain(tcw_pkg::OP_POP);
      plain(tcw_pkg::OP_POP);
      read_cell(11'(CELL_COUNT - COLS));
      plain(tcw_pkg::OP_CLEAR);
      read_cell(11'(CELL_COUNT - 1));
      read_cell(11'(CELL_COUNT));
      read_cell(11'h7ff);
      plain(OP_SPARE);
   endtask

   task automatic random_phase(input int count);
      int sent;
      int sel;
      int n;
      sent = 0;
      plain(tcw_pkg::OP_CLEAR);
      sent++;
      while (sent < count) begin
         if ($urandom_range(0, 19) == 0) calm = !calm;
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            put(pick_code());
            sent++;
         end else if (sel < 45) begin
            read_cell($urandom_range(0, 1) ? near_cursor() : 11'($urandom));
            sent++;
         end else if (sel < 53) begin
            set_color($urandom_range(0, 1) ? tcw_pkg::OP_SET_BG : tcw_pkg::OP_SET_FG,
                      4'($urandom));
            stamp(sent);
            sent++;
         end else if (sel < 61) begin
            plain($urandom_range(0, 1) ? tcw_pkg::OP_PUSH : tcw_pkg::OP_POP);
            sent++;
         end else if (sel < 63) begin
            plain(tcw_pkg::OP_CLEAR);
            sent++;
         end else if (sel < 65) begin
            plain(OP_SPARE);
            sent++;
         end else if (sel < 70) begin
            // fill the stack to near or past full, then pop it to near or past empty
            n = $urandom_range(30, 36);
            repeat (n) begin
               if ($urandom_range(0, 1)) begin
                  set_color($urandom_range(0, 1) ? tcw_pkg::OP_SET_BG : tcw_pkg::OP_SET_FG,
                            4'($urandom));
                  sent++;
               end
               plain(tcw_pkg::OP_PUSH);
               sent++;
            end
            n = $urandom_range(30, 36);
            repeat (n) begin
               plain(tcw_pkg::OP_POP);
               sent++;
               if ($urandom_range(0, 3) == 0) stamp(sent);
            end
         end else if (sel < 88) begin
            // a line of text, ended by a newline or a carriage return
            n = $urandom_range(1, 100);
            repeat (n) put(printable());
            put($urandom_range(0, 9) < 7 ? tcw_pkg::CH_LF : tcw_pkg::CH_CR);
            sent += n + 1;
            n = $urandom_range(0, 3);
            repeat (n) read_cell(near_cursor());
            sent += n;
         end else begin
            // run of newlines, scrolling once the bottom row is reached
            n = $urandom_range(2, 26);
            repeat (n) put(tcw_pkg::CH_LF);
            sent += n;
            read_cell(11'($urandom_range(0, CELL_COUNT - 1)));
            sent++;
         end
      end
   endtask

   // Result side: draw a stall length per beat, then wait for the beat
   initial begin : rsp_stall_gen
      int hold;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.compare_report(rsp_payload);
   end

   initial begin : stimulus
      logic [3:0] bg_table [5];
      logic [3:0] fg_table [5];
      bg_table = '{4'hf, 4'h0, 4'h0, 4'hf, 4'h0};
      fg_table = '{4'hf, 4'h0, 4'h0, 4'h0, 4'h7};
      board        = new();
      calm         = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= tcw_pkg::CSR_DEF_BG;
      csr_wdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed_checks();
      for (int p = 0; p < 5; p++) begin
         settle();
         if (p == 2) write_defaults(4'($urandom), 4'($urandom));
         else        write_defaults(bg_table[p], fg_table[p]);
         random_phase(135);
      end
      settle();
      repeat (40) @(posedge clock);

      if (board.faults == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #60ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
